// ===== rtl/modinv_pkg.sv =====
// Shared types for the modular inverse block.
// Holds the command and status structs between the controller and the datapath.
// No dependencies.
package modinv_pkg;

    // Commands issued by the controller, at most one active at a time
    typedef struct packed {
        logic load;          // capture a new operand pair
        logic step_start;    // set up divider for r_prev / r_cur
        logic reduce_start;  // set up divider for c_cur mod modulus
        logic iterate;       // one restoring-division bit
        logic update;        // retire one Euclid step
        logic write_out;     // load the result register
    } t_cmd;

    // Status flags returned by the datapath
    typedef struct packed {
        logic mod_lt2;       // modulus below two
        logic rem_zero;      // current remainder is zero
        logic rem_one;       // current remainder is one
        logic iter_last;     // divider is on its final bit
    } t_status;

endpackage

// ===== rtl/modular_inverse_ext_euclid.sv =====
// Modular inverse by the extended Euclidean algorithm, one transaction at a time.
// Each transaction runs s Euclid steps, up to ~1.44*WIDTH (none for a modulus below two),
// then a final reduction when an inverse exists; the next one is taken only after that.
// The shared divider gives one bit a cycle.
// Reset (synchronous, active low) clears the sequencer and the output valid and stalls input.
module modular_inverse_ext_euclid #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [WIDTH-1:0] i_value_in,
    input  logic [WIDTH-1:0] i_modulus_in,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [WIDTH-1:0] o_inverse_out,
    output logic             o_has_inverse
);
    import modinv_pkg::*;

    // Command and status between the sequencer and the datapath
    t_cmd    cmd;
    t_status status;

    // Controller: accepts a transaction only when idle; the result register
    // lets it take the next transaction while the previous result waits.
    modinv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: each Euclid step runs one bit-serial division that yields
    // the remainder and, by shift-and-add on the quotient bits, q*c_cur.
    // The final coefficient is reduced by the same divider.
    modinv_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_value_in    (i_value_in),
        .i_modulus_in  (i_modulus_in),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_inverse_out (o_inverse_out),
        .o_has_inverse (o_has_inverse)
    );

endmodule

// ===== rtl/modinv_datapath.sv =====
// Datapath of the modular inverse block: remainders, coefficients and a
// shared bit-serial divider with a shift-and-add product accumulator.
// Depends on modinv_pkg.
module modinv_datapath #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic [WIDTH-1:0]     i_value_in,
    input  logic [WIDTH-1:0]     i_modulus_in,
    input  modinv_pkg::t_cmd     i_cmd,
    output modinv_pkg::t_status  o_status,
    output logic [WIDTH-1:0]     o_inverse_out,
    output logic                 o_has_inverse
);
    import modinv_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_r_prev;
    logic [WIDTH-1:0] r_r_cur;
    logic [WIDTH-1:0] r_c_prev;
    logic [WIDTH-1:0] r_c_cur;
    logic             r_neg;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_dvsr;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_acc;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_inv;
    logic             r_found;

    logic [WIDTH:0]   rem_sh;
    logic             q_bit;
    logic [WIDTH:0]   rem_diff;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_acc;
    logic             found;
    logic [WIDTH-1:0] inv;

    // One restoring-division bit; the quotient bit also drives the product
    always_comb begin
        rem_sh   = {r_rem, r_dvd[WIDTH-1]};
        q_bit    = rem_sh >= {1'b0, r_dvsr};
        rem_diff = rem_sh - {1'b0, r_dvsr};
        n_rem    = q_bit ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        n_acc    = {r_acc[WIDTH-2:0], 1'b0} + (q_bit ? r_c_cur : '0);
    end

    always_comb begin
        o_status.mod_lt2   = (r_mod[WIDTH-1:1] == '0);
        o_status.rem_zero  = (r_r_cur == '0);
        o_status.rem_one   = (r_r_cur == WIDTH'(1));
        o_status.iter_last = (r_cnt == CW'(WIDTH - 1));
        found = !o_status.mod_lt2 && o_status.rem_one;
        // Reduced magnitude sits in r_rem after the final division
        if (!found) begin
            inv = '0;
        end else if (r_neg && (r_rem != '0)) begin
            inv = r_mod - r_rem;
        end else begin
            inv = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod    <= i_modulus_in;
            r_r_prev <= i_modulus_in;
            r_r_cur  <= i_value_in;
            r_c_prev <= '0;
            r_c_cur  <= WIDTH'(1);
            r_neg    <= 1'b0;
        end
        if (i_cmd.step_start) begin
            r_dvd  <= r_r_prev;
            r_dvsr <= r_r_cur;
            r_rem  <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.reduce_start) begin
            r_dvd  <= r_c_cur;
            r_dvsr <= r_mod;
            r_rem  <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end
        if (i_cmd.iterate) begin
            r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.update) begin
            r_r_prev <= r_r_cur;
            r_r_cur  <= r_rem;
            r_c_prev <= r_c_cur;
            r_c_cur  <= r_acc + r_c_prev;
            r_neg    <= ~r_neg;
        end
        if (i_cmd.write_out) begin
            r_inv   <= inv;
            r_found <= found;
        end
    end

    assign o_inverse_out = r_inv;
    assign o_has_inverse = r_found;

endmodule

// ===== rtl/modinv_ctrl.sv =====
// Controller of the modular inverse block: sequences Euclid steps, the
// final reduction and the output handshake. Depends on modinv_pkg.
module modinv_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  modinv_pkg::t_status  i_status,
    output modinv_pkg::t_cmd     o_cmd
);
    import modinv_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SDIV   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_RDIV   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_valid;
    logic       n_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        // drop the held result once it is taken
        n_valid = r_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.mod_lt2 || i_status.rem_zero) begin
                    n_state = S_OUT;
                end else if (i_status.rem_one) begin
                    o_cmd.reduce_start = 1'b1;
                    n_state            = S_RDIV;
                end else begin
                    o_cmd.step_start = 1'b1;
                    n_state          = S_SDIV;
                end
            end
            S_SDIV: begin
                o_cmd.iterate = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_RDIV: begin
                o_cmd.iterate = 1'b1;
                if (i_status.iter_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_valid || !i_out_stall) begin
                    o_cmd.write_out = 1'b1;
                    n_valid         = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // hold off the sender while in reset or busy
    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_valid;

endmodule

// ===== bench/tb_modular_inverse_ext_euclid.sv =====
// Self-checking testbench for the extended-Euclid modular inverse block.
// Depends only on the RTL top level modular_inverse_ext_euclid (WIDTH = 32).
`timescale 1ns / 100ps

module tb_modular_inverse_ext_euclid;

    localparam int WIDTH       = 32;
    localparam int NUM_RANDOM  = 930;
    localparam int QUIET_FIRST = 300;   // no idling on either side from here...
    localparam int QUIET_LAST  = 480;   // ...up to here
    localparam int DRAIN_ITEM  = 600;   // sender waits for an empty scoreboard here
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic             found;
    } inverse_t;

    // Hold expected inverses in arrival order and compare results against them.
    class inverse_scoreboard;
        inverse_t    pending[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Run extended Euclid on (modulus, value), keeping coefficient magnitudes
        // with an alternating sign.
        function inverse_t predict_inverse(logic [WIDTH-1:0] value,
                                           logic [WIDTH-1:0] modulus);
            longint unsigned rem_old, rem_new, coef_old, coef_new;
            longint unsigned quot, rem_next, coef_next, mag;
            bit              negative;
            bit              done;
            inverse_t        res;
            res.inverse = '0;
            res.found   = 1'b0;
            if (modulus >= 2) begin
                rem_old  = modulus;
                rem_new  = value;
                coef_old = 0;
                coef_new = 1;
                negative = 1'b0;
                done     = 1'b0;
                while (!done) begin
                    if (rem_new == 0) begin
                        done = 1'b1;
                    end else if (rem_new == 1) begin
                        res.found = 1'b1;
                        done      = 1'b1;
                    end else begin
                        quot      = rem_old / rem_new;
                        rem_next  = rem_old % rem_new;
                        coef_next = coef_old + quot * coef_new;
                        rem_old   = rem_new;
                        rem_new   = rem_next;
                        coef_old  = coef_new;
                        coef_new  = coef_next;
                        negative  = !negative;
                    end
                end
                if (res.found) begin
                    mag = coef_new % modulus;
                    res.inverse = (negative && mag != 0) ? WIDTH'(modulus - mag)
                                                         : WIDTH'(mag);
                end
            end
            return res;
        endfunction

        function void note_request(logic [WIDTH-1:0] value, logic [WIDTH-1:0] modulus);
            pending.push_back(predict_inverse(value, modulus));
        endfunction

        task report_mismatch(string what);
            if (mismatches < 50)
                $display("MISMATCH @%0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [WIDTH-1:0] inverse, logic found);
            inverse_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result inverse=%0h found=%b",
                                          inverse, found));
                return;
            end
            want = pending.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("has_inverse got %b want %b", found, want.found));
            if (inverse !== want.inverse)
                report_mismatch($sformatf("inverse_out got %0h want %0h",
                                          inverse, want.inverse));
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [WIDTH-1:0] i_value_in;
    logic [WIDTH-1:0] i_modulus_in;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [WIDTH-1:0] o_inverse_out;
    logic             o_has_inverse;

    inverse_scoreboard sb = new();
    bit                quiet;        // suppress idling on both channels
    int                item_count;

    modular_inverse_ext_euclid #(
        .WIDTH (WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_value_in    (i_value_in),
        .i_modulus_in  (i_modulus_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_inverse_out (o_inverse_out),
        .o_has_inverse (o_has_inverse)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Stall the result channel at random, with odds of about 11 in 100, never in the quiet stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < 11);
    end

    // Check every result transaction; the stall read here is the pre-edge value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_inverse_out, o_has_inverse);
    end

    // Offer one request transaction, idling at random first, and note it once taken.
    // Every branch leaves exactly one update of the valid per time step.
    task automatic drive_request(input logic [WIDTH-1:0] value,
                                 input logic [WIDTH-1:0] modulus);
        while (!quiet && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_value_in   <= value;
        i_modulus_in <= modulus;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(value, modulus);
        item_count++;
    endtask

    // Pick a random operand pair; keep most operands small since the divider
    // runs one bit per cycle and the step count grows with operand size.
    task automatic pick_pair(output logic [WIDTH-1:0] value,
                             output logic [WIDTH-1:0] modulus);
        int unsigned sel;
        int unsigned factor;
        sel = $urandom_range(99);
        if (sel < 40) begin
            modulus = $urandom_range(65535, 2);
            value   = $urandom_range(65535, 0);
        end else if (sel < 52) begin
            modulus = $urandom_range(255, 2);
            value   = $urandom_range(255, 0);
        end else if (sel < 77) begin
            modulus = $urandom;
            value   = $urandom;
        end else if (sel < 85) begin
            // force a common factor so there is no inverse
            factor  = $urandom_range(60, 2);
            modulus = factor * $urandom_range(1000000, 1);
            value   = factor * $urandom_range(1000000, 0);
        end else if (sel < 91) begin
            // modulus of zero or one
            modulus = $urandom_range(1, 0);
            value   = $urandom;
        end else begin
            // value at or around the modulus
            modulus = $urandom;
            case ($urandom_range(3))
                0: value = '0;
                1: value = modulus;
                2: value = modulus - 1;
                default: value = modulus + $urandom_range(1000, 1);
            endcase
        end
    endtask

    initial begin
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] dir_value[$];
        logic [WIDTH-1:0] dir_modulus[$];
        int               wait_cycles;

        // Drive every input to a known value and hold reset.
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_value_in   = '0;
        i_modulus_in = '0;
        i_out_stall  = 1'b0;
        quiet        = 1'b0;
        item_count   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: modulus below two, zero value, value not below the
        // modulus, common factors, full-scale operands, longest Euclid chain.
        dir_value   = '{32'd0, 32'd5, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1,
                        32'd0, 32'd3, 32'd10, 32'd7, 32'd14, 32'd2,
                        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd1,
                        32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1836311903,
                        32'd2971215073, 32'd123456789, 32'hAAAA_AAAA};
        dir_modulus = '{32'd0, 32'd0, 32'd1, 32'd1, 32'd2, 32'd1,
                        32'd7, 32'd7, 32'd7, 32'd7, 32'd21, 32'd4,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd2971215073,
                        32'd1836311903, 32'd1000000007, 32'h5555_5555};
        foreach (dir_value[k])
            drive_request(dir_value[k], dir_modulus[k]);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            quiet = (item_count >= QUIET_FIRST) && (item_count < QUIET_LAST);
            if (item_count == DRAIN_ITEM) begin
                // Drop valid and hold off until every expected result is back.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            pick_pair(value, modulus);
            drive_request(value, modulus);
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then idle a little longer to catch stray results.
        while (sb.pending.size() != 0) @(posedge i_clk);
        wait_cycles = TAIL_CYCLES;
        repeat (wait_cycles) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run with both sides stalling.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
